// ===== hdl/akx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key expansion package
// Shared types, constants and byte functions for the key schedule.
// ----------------------------------------------------------------------------
package akx_pkg;

	localparam int unsigned KEY_W      = 64;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned INDEX_W    = 6;
	localparam int unsigned WIN_BYTES  = 16;
	localparam int unsigned KEY_WORDS  = 4;

	localparam logic [INDEX_W-1:0] KEY_LAST_INDEX = 6'd3;
	localparam logic [INDEX_W-1:0] LAST_INDEX     = 6'd43;
	localparam logic [7:0]         RC_SEED        = 8'h8d;
	localparam logic [8:0]         AES_POLY       = 9'h11b;

	typedef struct packed {
		logic [KEY_W-1:0] key_high;
		logic [KEY_W-1:0] key_low;
	} key_t;

	typedef struct packed {
		logic [INDEX_W-1:0] word_index;
		logic [WORD_W-1:0]  word_value;
		logic               last_word;
	} word_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_KEY  = 4'b0010,
		S_CALC = 4'b0100,
		S_PUT  = 4'b1000
	} state_t;

	// double in GF(2^8)
	function automatic logic [7:0] gf_double(input logic [7:0] b);
		logic [8:0] v;
		v = {b, 1'b0};
		if (v[8]) begin
			v = v ^ AES_POLY;
		end
		return v[7:0];
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX[b];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/akx_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key expansion channels
// Valid/ready channels for the key input and the schedule word output.
// ----------------------------------------------------------------------------
interface akx_key_if;
	logic          valid;
	logic          ready;
	akx_pkg::key_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface akx_word_if;
	logic           valid;
	logic           ready;
	akx_pkg::word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/aes128_key_expansion.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Expands one 128-bit key into the 44 schedule words, one byte per cycle.
// The key is taken only while idle; the four key words are emitted first, then each
// derived word is built in four byte steps through one shared S-box and then output.
// The output stalls on back-pressure; a new key is taken only after the last word.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module aes128_key_expansion (
	input  wire                clk,
	input  wire                arst_n,
	akx_key_if.sink            key,
	akx_word_if.source         word
);

	akx_pkg::state_t state_q;
	logic [7:0]                       win_q [akx_pkg::WIN_BYTES];
	logic [akx_pkg::INDEX_W-1:0]      idx_q;
	logic [1:0]                       byte_q;
	logic [7:0]                       rc_q;
	logic                             out_valid_q;
	akx_pkg::word_t                   out_data_q;

	logic                             slot_free;
	logic                             key_take;
	logic                             out_load;
	akx_pkg::word_t                   out_next;
	logic                             rot;
	logic [7:0]                       rc_next;
	logic [7:0]                       sb_in;
	logic [7:0]                       t_byte;
	logic [7:0]                       new_byte;

	assign slot_free = !out_valid_q || word.ready;
	assign key.ready = (state_q == akx_pkg::S_IDLE);
	assign key_take  = key.valid && key.ready;

	assign rot      = (idx_q[1:0] == 2'd0);
	assign rc_next  = akx_pkg::gf_double(rc_q);
	assign sb_in    = (byte_q == 2'd3) ? win_q[9] : win_q[13];

	always_comb begin
		if (rot) begin
			t_byte = akx_pkg::sbox(sb_in) ^ ((byte_q == 2'd0) ? rc_next : 8'h00);
		end else begin
			t_byte = win_q[12];
		end
	end

	assign new_byte = win_q[0] ^ t_byte;

	always_comb begin
		out_load = 1'b0;
		out_next.word_index = idx_q;
		out_next.last_word  = (idx_q == akx_pkg::LAST_INDEX);
		out_next.word_value = {win_q[12], win_q[13], win_q[14], win_q[15]};
		unique case (state_q)
			akx_pkg::S_KEY: begin
				out_load = slot_free;
				out_next.word_value = {win_q[0], win_q[1], win_q[2], win_q[3]};
			end
			akx_pkg::S_PUT: begin
				out_load = slot_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= akx_pkg::S_IDLE;
			idx_q   <= '0;
			byte_q  <= '0;
		end else begin
			unique case (state_q)
				akx_pkg::S_IDLE: begin
					if (key_take) begin
						idx_q   <= '0;
						state_q <= akx_pkg::S_KEY;
					end
				end
				akx_pkg::S_KEY: begin
					if (out_load) begin
						idx_q <= idx_q + 6'd1;
						if (idx_q == akx_pkg::KEY_LAST_INDEX) begin
							byte_q  <= '0;
							state_q <= akx_pkg::S_CALC;
						end
					end
				end
				akx_pkg::S_CALC: begin
					byte_q <= byte_q + 2'd1;
					if (byte_q == 2'd3) begin
						state_q <= akx_pkg::S_PUT;
					end
				end
				akx_pkg::S_PUT: begin
					if (out_load) begin
						idx_q  <= idx_q + 6'd1;
						byte_q <= '0;
						if (idx_q == akx_pkg::LAST_INDEX) begin
							state_q <= akx_pkg::S_IDLE;
						end else begin
							state_q <= akx_pkg::S_CALC;
						end
					end
				end
				default: begin
					state_q <= akx_pkg::S_IDLE;
				end
			endcase
		end
	end

	// byte window: load key, rotate by a word while emitting it, shift in derived bytes
	always_ff @(posedge clk) begin
		if (key_take) begin
			for (int j = 0; j < 8; j++) begin
				win_q[j]     <= key.data.key_high[63-8*j -: 8];
				win_q[j + 8] <= key.data.key_low[63-8*j -: 8];
			end
			rc_q <= akx_pkg::RC_SEED;
		end else if (state_q == akx_pkg::S_KEY && out_load) begin
			for (int j = 0; j < 16; j++) begin
				win_q[j] <= win_q[(j + 4) % 16];
			end
		end else if (state_q == akx_pkg::S_CALC) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[15] <= new_byte;
			if (rot && byte_q == 2'd0) begin
				rc_q <= rc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (word.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_next;
		end
	end

	assign word.valid = out_valid_q;
	assign word.data  = out_data_q;

endmodule
`default_nettype wire
